// ----- hw/rtl/pss_pkg.sv -----
// Package for the particle swarm step unit: sizes, item kinds, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package pss_pkg;
  localparam int Particles  = 32;
  localparam int Dimensions = 16;
  localparam int PW = $clog2(Particles);
  localparam int DW = $clog2(Dimensions);
  localparam int AW = PW + DW;
  localparam logic [33:0] FitMax = 34'h3FFFFFFFF;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindUpdate = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  localparam logic [2:0] RegPosLimit = 3'd0;
  localparam logic [2:0] RegVelLimit = 3'd1;
  localparam logic [2:0] RegPGain    = 3'd2;
  localparam logic [2:0] RegSGain    = 3'd3;
  localparam logic [2:0] RegDims     = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         particle;
    logic [3:0]         dimension;
    logic signed [23:0] init_position;
    logic signed [23:0] init_velocity;
    logic [15:0]        rand_personal;
    logic [15:0]        rand_global;
    logic [16:0]        inertia;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] new_position;
    logic signed [23:0] new_velocity;
    logic [33:0]        particle_fitness;
    logic               fitness_done;
    logic [33:0]        best_fitness;
    logic [4:0]         best_particle;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the input item
    logic read;      // issue store reads
    logic mul1;      // first multiply stage
    logic mul2;      // second multiply stage
    logic finish;    // clamp, write back, fitness
    logic copy;      // one step of a copy walk
    logic commit;    // end item bookkeeping
  } pss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pb_copy;   // personal best copy needed
    logic gb_copy;   // global best copy needed
    logic copy_last; // copy walk at last dimension
    logic is_update;
    logic is_end;
  } pss_stat_t;
endpackage

// ----- hw/rtl/pss_if.sv -----
// Valid/ready channel interface carrying a payload of a given type.
// Depends on pss_pkg.
`timescale 1ns / 1ps
interface pss_in_if import pss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pss_out_if import pss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pss_ctrl.sv -----
// Sequencer for the particle swarm step unit.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_ctrl import pss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pss_stat_t stat_i,
  output pss_cmd_t  cmd_o
);
  typedef enum logic [2:0] {
    StIdle, StRead, StMul1, StMul2, StFinish, StCopy, StCommit
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Accept a new item once the output slot is empty or drains this cycle.
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.read    = state_q == StRead;
    cmd_o.mul1    = state_q == StMul1;
    cmd_o.mul2    = state_q == StMul2;
    cmd_o.finish  = state_q == StFinish;
    cmd_o.copy    = state_q == StCopy;
    cmd_o.commit  = state_q == StCommit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (cmd_o.capture) state_q <= StRead;
        StRead: begin
          if (stat_i.is_end) state_q <= StCommit;
          else if (stat_i.is_update) state_q <= StMul1;
          else state_q <= StFinish;
        end
        StMul1: state_q <= StMul2;
        StMul2: state_q <= StFinish;
        StFinish: begin
          if (stat_i.pb_copy) state_q <= StCopy;
          else begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        StCommit: begin
          if (stat_i.gb_copy) state_q <= StCopy;
          else begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        StCopy: begin
          if (stat_i.copy_last) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/pss_dp.sv -----
// Datapath for the particle swarm step unit: stores, multipliers, clamps, fitness.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_dp import pss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pss_cmd_t    cmd_i,
  output pss_stat_t   stat_o,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i,
  output out_item_t   res_o
);
  // configuration
  logic [22:0] pos_lim_q, vel_lim_q;
  logic [17:0] pgain_q, sgain_q;
  logic [4:0]  dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lim_q <= 23'd6553600;
      vel_lim_q <= 23'd983040;
      pgain_q   <= 18'd131072;
      sgain_q   <= 18'd131072;
      dims_q    <= 5'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPosLimit: pos_lim_q <= cfg_data_i;
        RegVelLimit: vel_lim_q <= cfg_data_i;
        RegPGain:    pgain_q   <= cfg_data_i[17:0];
        RegSGain:    sgain_q   <= cfg_data_i[17:0];
        RegDims:     dims_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0] nd;
  always_comb begin
    nd = dims_q;
    if (nd == 5'd0) nd = 5'd1;
    if (nd > 5'(Dimensions)) nd = 5'(Dimensions);
  end

  // memories
  logic signed [23:0] pos_mem [Particles*Dimensions];
  logic signed [23:0] vel_mem [Particles*Dimensions];
  logic signed [23:0] pb_mem  [Particles*Dimensions];
  logic [33:0]        pbf_mem [Particles];
  logic signed [23:0] gb_mem  [Dimensions];

  in_item_t it_q;
  logic signed [23:0] x0_q, v0_q, pb_q, gb_q;
  logic [33:0]        pbf_q;
  logic [17:0]        gp_q, gs_q;
  logic signed [40:0] t0_q;
  logic signed [42:0] p1_q, p2_q;

  logic [33:0] acc_q, gbf_q, cf_q;
  logic [4:0]  gbi_q, ci_q;
  logic        cv_q;
  logic        gb_copy_q;
  logic [DW-1:0] cnt_q, wa_q;
  logic [PW-1:0] cp_q;
  logic signed [23:0] cdata_q;
  logic        cstage_q;
  out_item_t   res_q, res_d;

  wire in_range = ({1'b0, it_q.particle} < 6'(Particles)) &&
                  ({1'b0, it_q.dimension} < 5'(Dimensions));
  wire [AW-1:0] idx = {it_q.particle[PW-1:0], it_q.dimension[DW-1:0]};

  // multiply operands
  wire signed [24:0] dp = 25'(pb_q) - 25'(x0_q);
  wire signed [24:0] dg = 25'(gb_q) - 25'(x0_q);

  // finish-stage math
  logic signed [43:0] vsum;
  logic signed [23:0] vc, xc, xl;
  logic signed [24:0] xs;
  logic [47:0] sq;
  logic [34:0] accn;
  always_comb begin
    vsum = 44'(t0_q >>> 16) + 44'(p1_q >>> 16) + 44'(p2_q >>> 16);
    if (vsum > $signed({21'd0, vel_lim_q})) vc = $signed({1'b0, vel_lim_q});
    else if (vsum < -$signed({21'd0, vel_lim_q})) vc = -$signed({1'b0, vel_lim_q});
    else vc = vsum[23:0];
    xs = 25'(x0_q) + 25'(vc);
    if (xs > $signed({2'd0, pos_lim_q})) xc = $signed({1'b0, pos_lim_q});
    else if (xs < -$signed({2'd0, pos_lim_q})) xc = -$signed({1'b0, pos_lim_q});
    else xc = xs[23:0];
    xl = (it_q.kind == KindLoad) ? it_q.init_position : xc;
    sq = 48'(xl * xl);
    accn = ((it_q.dimension == 4'd0) ? 35'd0 : 35'(acc_q)) + 35'(sq[47:16]);
    if (accn > 35'(FitMax)) accn = 35'(FitMax);
  end

  wire counts = in_range && (it_q.kind == KindLoad || it_q.kind == KindUpdate)
                && (5'(it_q.dimension) < nd);
  wire last = counts && (5'(it_q.dimension) == nd - 5'd1);
  wire pb_better = it_q.kind == KindLoad || accn[33:0] < pbf_q;

  assign stat_o.is_update = it_q.kind == KindUpdate && in_range;
  assign stat_o.is_end    = it_q.kind == KindEnd || it_q.kind == 2'd3 || !in_range;
  assign stat_o.pb_copy   = last && it_q.kind == KindUpdate && accn[33:0] < pbf_q;
  assign stat_o.gb_copy   = it_q.kind == KindEnd && cv_q && cf_q < gbf_q;
  assign stat_o.copy_last = cstage_q && wa_q == DW'(Dimensions - 1);
  assign res_o = res_q;

  // result register contents for the finish and commit steps
  always_comb begin
    res_d = res_q;
    if (cmd_i.finish) begin
      res_d = '0;
      res_d.best_fitness  = gbf_q;
      res_d.best_particle = gbi_q;
      res_d.new_position  = xl;
      res_d.new_velocity  = (it_q.kind == KindLoad) ? it_q.init_velocity : vc;
      if (last) begin
        res_d.particle_fitness = accn[33:0];
        res_d.fitness_done     = 1'b1;
      end
    end else if (cmd_i.commit) begin
      res_d = '0;
      if (stat_o.gb_copy) begin
        res_d.best_fitness  = cf_q;
        res_d.best_particle = ci_q;
      end else begin
        res_d.best_fitness  = gbf_q;
        res_d.best_particle = gbi_q;
      end
    end
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      x0_q  <= pos_mem[idx];
      v0_q  <= vel_mem[idx];
      pb_q  <= pb_mem[idx];
      gb_q  <= gb_mem[it_q.dimension[DW-1:0]];
      pbf_q <= pbf_mem[it_q.particle[PW-1:0]];
    end
    if (cmd_i.finish && in_range && it_q.kind != KindEnd && it_q.kind != 2'd3) begin
      pos_mem[idx] <= xl;
      vel_mem[idx] <= (it_q.kind == KindLoad) ? it_q.init_velocity : vc;
      if (it_q.kind == KindLoad) pb_mem[idx] <= it_q.init_position;
      if (last && pb_better) pbf_mem[it_q.particle[PW-1:0]] <= accn[33:0];
    end
    // copy walk: read at cnt into cdata_q, then write that entry at wa
    if (cmd_i.copy) begin
      if (gb_copy_q) cdata_q <= pb_mem[{cp_q, cnt_q}];
      else           cdata_q <= pos_mem[{cp_q, cnt_q}];
      if (cstage_q) begin
        if (gb_copy_q) gb_mem[wa_q] <= cdata_q;
        else           pb_mem[{cp_q, wa_q}] <= cdata_q;
      end
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) it_q <= item_i;
    if (cmd_i.mul1) begin
      gp_q <= 18'((34'(pgain_q) * 34'(it_q.rand_personal)) >> 16);
      gs_q <= 18'((34'(sgain_q) * 34'(it_q.rand_global)) >> 16);
      t0_q <= 41'(v0_q * $signed({1'b0, it_q.inertia}));
    end
    if (cmd_i.mul2) begin
      p1_q <= 43'($signed({1'b0, gp_q}) * dp);
      p2_q <= 43'($signed({1'b0, gs_q}) * dg);
    end
    if (cmd_i.read && !(it_q.kind == KindUpdate)) begin
      t0_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
    end
  end

  // control-bearing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; gbf_q <= FitMax; gbi_q <= '0;
      cf_q <= FitMax; ci_q <= '0; cv_q <= 1'b0;
      gb_copy_q <= 1'b0;
      cnt_q <= '0; wa_q <= '0; cp_q <= '0; cstage_q <= 1'b0;
      res_q <= '0;
    end else begin
      res_q <= res_d;
      if (cmd_i.finish) begin
        if (last) begin
          acc_q <= '0;
          if (pb_better && accn[33:0] < cf_q) begin
            cf_q <= accn[33:0];
            ci_q <= it_q.particle;
            cv_q <= 1'b1;
          end
        end else if (counts) begin
          acc_q <= accn[33:0];
        end
        gb_copy_q <= 1'b0;
        cp_q      <= it_q.particle[PW-1:0];
        cnt_q     <= '0;
        cstage_q  <= 1'b0;
      end
      if (cmd_i.commit) begin
        if (it_q.kind == KindEnd) begin
          if (stat_o.gb_copy) begin
            gbf_q <= cf_q; gbi_q <= ci_q;
          end
          cf_q <= FitMax; ci_q <= '0; cv_q <= 1'b0; acc_q <= '0;
        end
        gb_copy_q <= stat_o.gb_copy;
        cp_q      <= ci_q[PW-1:0];
        cnt_q     <= '0;
        cstage_q  <= 1'b0;
      end
      if (cmd_i.copy) begin
        cnt_q    <= cnt_q + DW'(1);
        wa_q     <= cnt_q;
        cstage_q <= 1'b1;
      end
    end
  end
endmodule

// ----- hw/rtl/particle_swarm_step_unit.sv -----
// Top level of the particle swarm step unit.
// Depends on pss_pkg, pss_if, pss_ctrl and pss_dp.
`timescale 1ns / 1ps
// Usage:
//   in_if carries one item per transaction: load (kind 0), update (kind 1)
//   or end of generation (kind 2). Every item yields exactly one result
//   transaction on out_if with the stored coordinate, the completed fitness
//   and the committed global best.
//   The configuration port writes one register per cycle (cfg_we_i); write
//   only while no item is in flight.
// Sequencing:
//   A load item passes through store read, then clamp and write back; an end
//   item through store read, then commit; an update through store read, gain
//   and inertia multiply, difference multiply, clamp and write back. The next
//   item is taken once the unit is back in idle at the earliest.
//   A personal-best or global-best copy walks the 16 dimensions through one
//   memory port, each entry read and then written from a register, overlapped,
//   before the result is valid.
//   One item is in flight at a time.
// Reset: configuration returns to its defaults, global best and candidate to
//   all ones; coordinate stores are undefined until loaded.
// Stall: the result is held in an output register; the next item is taken
//   once that register is empty or drains in the same cycle.
module particle_swarm_step_unit import pss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pss_in_if.sink      in_if,
  pss_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [22:0] cfg_data_i
);
  pss_cmd_t  cmd;
  pss_stat_t stat;

  pss_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pss_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .stat_o    (stat),
    .item_i    (in_if.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .res_o     (out_if.data)
  );
endmodule

// ----- sim/tb.sv -----
// Testbench for particle_swarm_step_unit: predicts every result transaction and
// compares it field by field. Depends on pss_pkg, pss_if and the unit's RTL.
`timescale 1ns / 1ps
import pss_pkg::*;

class swarm_scoreboard;
  // predicted state of the swarm
  longint          pos [Particles*Dimensions];
  longint          vel [Particles*Dimensions];
  longint          pbest_pos [Particles*Dimensions];
  longint unsigned pbest_fit [Particles];
  longint          gbest_pos [Dimensions];
  longint unsigned gbest_fit, acc, cand_fit;
  int unsigned     gbest_idx, cand_idx;
  bit              cand_valid;
  longint unsigned pos_lim, vel_lim, p_gain, s_gain, dims;
  out_item_t       pending [$];
  int              errors;

  function new();
    foreach (pos[i]) begin
      pos[i] = 0; vel[i] = 0; pbest_pos[i] = 0;
    end
    foreach (pbest_fit[i]) pbest_fit[i] = 0;
    foreach (gbest_pos[i]) gbest_pos[i] = 0;
    gbest_fit = FitMax; gbest_idx = 0; acc = 0;
    cand_fit = FitMax; cand_idx = 0; cand_valid = 0;
    pos_lim = 6553600; vel_lim = 983040; p_gain = 131072; s_gain = 131072;
    dims = 10;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [22:0] val);
    case (idx)
      RegPosLimit: pos_lim = longint'(val);
      RegVelLimit: vel_lim = longint'(val);
      RegPGain:    p_gain = longint'(val[17:0]);
      RegSGain:    s_gain = longint'(val[17:0]);
      RegDims:     dims = longint'(val[4:0]);
      default: ;
    endcase
  endfunction

  function longint clamp(longint x, longint unsigned lim);
    longint l;
    l = longint'(lim);
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  // Predict the result of one accepted item and queue it.
  function void note_item(in_item_t it);
    out_item_t r;
    longint x, v, x0, gp, gs, t0, t1, t2;
    longint unsigned nd, sq, sum;
    int idx, p, d;
    r = '0;
    x = 0; v = 0;
    p = int'(it.particle); d = int'(it.dimension);
    idx = p * Dimensions + d;
    if (it.kind == KindEnd) begin
      if (cand_valid && cand_fit < gbest_fit) begin
        gbest_fit = cand_fit;
        gbest_idx = cand_idx;
        for (int k = 0; k < Dimensions; k++)
          gbest_pos[k] = pbest_pos[cand_idx*Dimensions + k];
      end
      cand_fit = FitMax; cand_idx = 0; cand_valid = 0; acc = 0;
    end else if (it.kind == KindLoad || it.kind == KindUpdate) begin
      nd = (dims < 1) ? 1 : (dims > Dimensions) ? Dimensions : dims;
      if (it.kind == KindLoad) begin
        x = longint'($signed(it.init_position));
        v = longint'($signed(it.init_velocity));
        pbest_pos[idx] = x;
      end else begin
        x0 = pos[idx];
        gp = longint'((p_gain * it.rand_personal) >> 16);
        gs = longint'((s_gain * it.rand_global) >> 16);
        t0 = (vel[idx] * longint'(it.inertia)) >>> 16;
        t1 = (gp * (pbest_pos[idx] - x0)) >>> 16;
        t2 = (gs * (gbest_pos[d] - x0)) >>> 16;
        v = clamp(t0 + t1 + t2, vel_lim);
        x = clamp(x0 + v, pos_lim);
      end
      pos[idx] = x;
      vel[idx] = v;
      if (d < nd) begin
        sq = longint'(x * x) >>> 16;
        sum = ((d == 0) ? 0 : acc) + sq;
        if (sum > FitMax) sum = FitMax;
        acc = sum;
        if (d == nd - 1) begin
          bit improved;
          r.particle_fitness = sum[33:0];
          r.fitness_done = 1'b1;
          acc = 0;
          improved = 1;
          if (it.kind == KindLoad) begin
            pbest_fit[p] = sum;
          end else if (sum < pbest_fit[p]) begin
            pbest_fit[p] = sum;
            for (int k = 0; k < Dimensions; k++)
              pbest_pos[p*Dimensions + k] = pos[p*Dimensions + k];
          end else begin
            improved = 0;
          end
          if (improved && sum < cand_fit) begin
            cand_fit = sum; cand_idx = p; cand_valid = 1;
          end
        end
      end
    end
    r.new_position = x[23:0];
    r.new_velocity = v[23:0];
    r.best_fitness = gbest_fit[33:0];
    r.best_particle = gbest_idx[4:0];
    pending.push_back(r);
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(out_item_t got);
    out_item_t e;
    if (pending.size() == 0) begin
      report("result with no prediction waiting");
      return;
    end
    e = pending.pop_front();
    if (got.new_position !== e.new_position)
      report($sformatf("new_position %0h, want %0h", got.new_position, e.new_position));
    if (got.new_velocity !== e.new_velocity)
      report($sformatf("new_velocity %0h, want %0h", got.new_velocity, e.new_velocity));
    if (got.particle_fitness !== e.particle_fitness)
      report($sformatf("particle_fitness %0h, want %0h",
                       got.particle_fitness, e.particle_fitness));
    if (got.fitness_done !== e.fitness_done)
      report($sformatf("fitness_done %0b, want %0b", got.fitness_done, e.fitness_done));
    if (got.best_fitness !== e.best_fitness)
      report($sformatf("best_fitness %0h, want %0h", got.best_fitness, e.best_fitness));
    if (got.best_particle !== e.best_particle)
      report($sformatf("best_particle %0d, want %0d", got.best_particle, e.best_particle));
  endtask
endclass

module tb;
  import pss_pkg::*;

  // kind code the unit treats as an end item without a commit
  localparam logic [1:0] KindSpare = 2'd3;
  localparam int WatchdogLimit = 6000;
  localparam int LongHold = 400;
  localparam int SettleCycles = 60;
  // particles in play: every fourth index ending at the top one
  localparam int UsedParticles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [22:0] cfg_data_i;

  pss_in_if  in_ch ();
  pss_out_if out_ch ();

  particle_swarm_step_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  swarm_scoreboard board = new();
  bit hold_request = 0;
  int idle_cycles = 0;

  // 8 ns clock
  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // Count cycles without any transaction; give up when the unit hangs.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Offer one item after a gap; keep valid high across back-to-back items.
  task send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_item(it);
  endtask

  // Drop valid, then hold until every predicted result has drained.
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    // let a trailing copy walk finish
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task configure(logic [22:0] pl, logic [22:0] vl, logic [22:0] pg,
                 logic [22:0] sg, logic [22:0] nd);
    drain();
    write_reg(RegPosLimit, pl);
    write_reg(RegVelLimit, vl);
    write_reg(RegPGain, pg);
    write_reg(RegSGain, sg);
    write_reg(RegDims, nd);
  endtask

  function automatic int used_particle(int k);
    return k * 4 + 3;
  endfunction

  function automatic int pick_particle();
    return used_particle($urandom_range(0, UsedParticles - 1));
  endfunction

  function automatic in_item_t make_load(int p, int d, logic [23:0] x, logic [23:0] v);
    in_item_t it;
    it = '0;
    it.kind = KindLoad;
    it.particle = 5'(p);
    it.dimension = 4'(d);
    it.init_position = x;
    it.init_velocity = v;
    // junk in the update-only fields must be ignored
    it.rand_personal = 16'($urandom());
    it.rand_global = 16'($urandom());
    it.inertia = 17'($urandom());
    return it;
  endfunction

  function automatic in_item_t make_update(int p, int d, int rp, int rg, int w);
    in_item_t it;
    it = '0;
    it.kind = KindUpdate;
    it.particle = 5'(p);
    it.dimension = 4'(d);
    it.init_position = 24'($urandom());
    it.init_velocity = 24'($urandom());
    it.rand_personal = 16'(rp);
    it.rand_global = 16'(rg);
    it.inertia = 17'(w);
    return it;
  endfunction

  function automatic in_item_t make_marker(logic [1:0] k);
    in_item_t it;
    it = 108'({$urandom(), $urandom(), $urandom(), $urandom()});
    it.kind = k;
    return it;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 24'($urandom());
      1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($signed($urandom_range(0, 2*983040)) - 983040);
    endcase
  endfunction

  function automatic in_item_t rand_update(int p, int d);
    return make_update(p, d, $urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65536));
  endfunction

  // Random traffic: mostly whole-particle sweeps, some closed by end items.
  task random_phase(int n_items);
    int sent, p, nd, stop_at;
    sent = 0;
    nd = (board.dims < 1) ? 1 : (board.dims > Dimensions) ? Dimensions : int'(board.dims);
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          send_item(make_marker($urandom_range(0, 1) ? KindEnd : KindSpare));
          sent++;
        end
        1: begin
          p = pick_particle();
          for (int d = 0; d < nd; d++) begin
            send_item(make_load(p, d, rand_coord(), rand_coord()));
            sent++;
          end
        end
        2: begin
          send_item(make_marker(KindEnd));
          sent++;
        end
        default: begin
          p = pick_particle();
          // break some sweeps early or run them past the dimensions in use
          stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, Dimensions - 1) : nd - 1;
          for (int d = 0; d <= stop_at; d++) begin
            send_item(rand_update(p, d));
            sent++;
          end
          if ($urandom_range(0, 2) == 0) begin
            send_item(make_marker(KindEnd));
            sent++;
          end
        end
      endcase
    end
    send_item(make_marker(KindEnd));
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      board.check_result(out_ch.data);
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegPosLimit;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every coordinate of the particles in play so no later read hits
    // an empty entry, then commit a global best.
    write_reg(RegDims, 23'd16);
    for (int k = 0; k < UsedParticles; k++)
      for (int d = 0; d < Dimensions; d++)
        send_item(make_load(used_particle(k), d,
                            24'($signed($urandom_range(0, 2*655360)) - 655360),
                            24'($signed($urandom_range(0, 2*65536)) - 65536)));
    send_item(make_marker(KindEnd));

    // Directed: field extremes, zero and full inertia and random factors,
    // the spare kind, a full improving sweep and commits.
    send_item(make_load(31, 15, 24'h800000, 24'h7FFFFF));
    send_item(make_load(31, 0, 24'h7FFFFF, 24'h800000));
    send_item(make_update(31, 15, 0, 0, 65536));
    send_item(make_update(31, 0, 65535, 65535, 0));
    send_item(make_update(31, 0, 65535, 0, 65536));
    send_item(make_marker(KindSpare));
    send_item(make_marker(KindEnd));
    for (int d = 0; d < Dimensions; d++)
      send_item(make_update(7, d, 65535, 65535, 0));
    send_item(make_marker(KindEnd));
    send_item(make_marker(KindEnd));

    // Sender pause until every result is back, with a long result hold-off
    // in the next phase.
    configure(23'd6553600, 23'd983040, 23'd131072, 23'd131072, 23'd10);
    hold_request = 1;
    random_phase(70);

    configure(23'h7FFFFF, 23'h7FFFFF, 23'h3FFFF, 23'h3FFFF, 23'd16);
    random_phase(70);

    configure(23'd1, 23'd1, 23'd0, 23'd0, 23'd1);
    random_phase(70);

    // dims of zero acts as one
    configure(23'($urandom_range(1, 23'h7FFFFF)), 23'($urandom_range(1, 23'h7FFFFF)),
              23'($urandom_range(0, 23'h3FFFF)), 23'($urandom_range(0, 23'h3FFFF)), 23'd0);
    random_phase(70);

    // dims above the array size acts as the full size
    configure(23'($urandom_range(1, 23'h7FFFFF)), 23'($urandom_range(1, 23'h7FFFFF)),
              23'($urandom_range(0, 23'h3FFFF)), 23'($urandom_range(0, 23'h3FFFF)), 23'd31);
    random_phase(70);

    drain();
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
